// File: hw/rtl/qs_pkg.sv
`default_nettype none
package qs_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_MAX    = 24;
    localparam int SQRT_BITS     = 31;
    localparam int DIV_BITS      = 21;

    // configuration register indexes
    localparam logic CFG_T_EPSILON        = 1'b0;
    localparam logic CFG_LINEAR_THRESHOLD = 1'b1;

    localparam logic [16:0] T_EPSILON_RST        = 17'd0;
    localparam logic [14:0] LINEAR_THRESHOLD_RST = 15'd16382;

    // atan(2^-i) in Q30 radians, truncated
    localparam logic [29:0] ATAN_Q30 [CORDIC_MAX] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
        30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
        30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127
    };

    typedef struct packed {
        logic signed [15:0] first_w;
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] first_z;
        logic signed [15:0] second_w;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic signed [15:0] second_z;
        logic        [16:0] blend;
    } t_in;

    typedef struct packed {
        logic signed [15:0] result_w;
        logic signed [15:0] result_x;
        logic signed [15:0] result_y;
        logic signed [15:0] result_z;
    } t_out;

    // integer square root step: remainder and partial root
    typedef struct packed {
        logic [60:0] rem;
        logic [30:0] root;
    } t_sqrt;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
    } t_cordic;

    // restoring divider step; cap/ok ride along with the quotient
    typedef struct packed {
        logic [54:0] rem;
        logic [20:0] q;
        logic [32:0] d;
        logic        cap;
        logic        ok;
    } t_div;

    // per-transaction sideband carried along the pipeline
    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][15:0] b;
        logic [16:0]      t;
        logic [28:0]      dot;
        logic             at_eps;
        logic             big;
        logic             neg;
        logic             slerp;
        logic             degen;
    } t_sb;

endpackage
`default_nettype wire

// File: hw/rtl/qs_chan.sv
`default_nettype none
interface qs_chan #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/quaternion_slerp.sv
`default_nettype none
// Fixed-point quaternion slerp. Each input transaction carries q1, q2 (signed
// Q2.14) and blend t (Q0.16, 65536 = 1.0); each yields exactly one output
// transaction with the interpolated quaternion, Q2.14, rounded and saturated.
// t at or below t_epsilon returns q1, t of one or more returns q2 unchanged.
// Otherwise q2 is flipped onto the short arc; when the cosine exceeds
// linear_threshold (or the arc is degenerate) weights are 1-t and t, else
// sin((1-t)w)/sin(w) and sin(tw)/sin(w). The datapath is a chain of cells:
// 31 square-root cells, CORDIC_STAGES vectoring cells, three parallel rows of
// CORDIC_STAGES rotation cells and two rows of 21 divider cells. A new
// transaction is taken every clock while the chain is not stalled; each
// result passes through the whole cell chain and then the output register.
// Output backpressure stalls the chain only once its last stage holds a
// result behind a full output register. Configuration is written with
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only while no
// transaction is in flight, which the block itself does not enforce.
module quaternion_slerp #(
    parameter int CORDIC_STAGES = qs_pkg::CORDIC_STAGES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [16:0] i_cfg_data,
    qs_chan.sink             i_in,
    qs_chan.source           o_out
);
    localparam int N     = CORDIC_STAGES;
    localparam int NSQ   = qs_pkg::SQRT_BITS;
    localparam int NDV   = qs_pkg::DIV_BITS;
    // sideband slot of each stage output
    localparam int SB_SQ  = 3 + NSQ - 1;          // last sqrt cell
    localparam int SB_VEC = SB_SQ + N;            // last vectoring cell
    localparam int SB_ANG = SB_VEC + 1;           // angle multiply
    localparam int SB_ROT = SB_ANG + N;           // last rotation cell
    localparam int SB_PRE = SB_ROT + 1;           // divider setup
    localparam int SB_DIV = SB_PRE + NDV;         // last divider cell
    localparam int SB_WGT = SB_DIV + 1;           // weight select
    localparam int SB_PRD = SB_WGT + 1;           // products
    localparam int SBL    = SB_PRD + 1;

    // ---------------- configuration ----------------
    logic [16:0] r_eps;
    logic [14:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= qs_pkg::T_EPSILON_RST;
            r_thr <= qs_pkg::LINEAR_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qs_pkg::CFG_T_EPSILON:        r_eps <= i_cfg_data;
                qs_pkg::CFG_LINEAR_THRESHOLD: r_thr <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // Whole chain moves together; it may move whenever the last stage is empty
    // or the output register can take its result.
    logic en;
    logic r_v1;
    logic r_vl [SBL];
    logic r_out_valid;

    assign en          = !r_out_valid || o_out.ready || !r_vl[SBL-1];
    assign i_in.ready  = en;
    assign o_out.valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            for (int k = 0; k < SBL; k++) begin
                r_vl[k] <= 1'b0;
            end
        end else if (en) begin
            r_v1    <= i_in.valid;
            r_vl[0] <= r_v1;
            for (int k = 1; k < SBL; k++) begin
                r_vl[k] <= r_vl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_out.ready || !r_out_valid) begin
            r_out_valid <= r_vl[SBL-1];
        end
    end

    // ---------------- stage 1: capture, special cases, products ----------------
    logic [3:0][15:0]   r1_a;
    logic [3:0][15:0]   r1_b;
    logic [16:0]        r1_t;
    logic               r1_small;
    logic               r1_big;
    logic signed [31:0] r1_p [4];
    logic [3:0][15:0]   in_a;
    logic [3:0][15:0]   in_b;

    assign in_a = {i_in.data.first_z, i_in.data.first_y,
                   i_in.data.first_x, i_in.data.first_w};
    assign in_b = {i_in.data.second_z, i_in.data.second_y,
                   i_in.data.second_x, i_in.data.second_w};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a     <= in_a;
            r1_b     <= in_b;
            r1_t     <= i_in.data.blend;
            r1_small <= i_in.data.blend <= r_eps;
            r1_big   <= i_in.data.blend[16];
            for (int i = 0; i < 4; i++) begin
                r1_p[i] <= $signed(in_a[i]) * $signed(in_b[i]);
            end
        end
    end

    // ---------------- stage 2: dot product, short-arc sign ----------------
    qs_pkg::t_sb        r_sb [SBL];
    qs_pkg::t_sb        n_sb0;
    logic signed [33:0] dsum;
    logic        [33:0] dabs;

    always_comb begin
        dsum = 34'(r1_p[0]) + 34'(r1_p[1]) + 34'(r1_p[2]) + 34'(r1_p[3]);
        dabs = dsum[33] ? 34'(-dsum) : 34'(dsum);
        n_sb0.a      = r1_a;
        n_sb0.b      = r1_b;
        n_sb0.t      = r1_t;
        n_sb0.at_eps = r1_small;
        n_sb0.big    = r1_big;
        n_sb0.neg    = dsum[33];
        // cosine saturates at 1.0
        n_sb0.dot   = (dabs > 34'd268435456) ? 29'd268435456 : dabs[28:0];
        n_sb0.slerp = n_sb0.dot[28:14] <= r_thr;
        n_sb0.degen = n_sb0.dot == 29'd268435456;   // sine is exactly zero
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= n_sb0;
            for (int k = 1; k < SBL; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // ---------------- stages 3-4: 1 - c^2 in Q60 ----------------
    logic [57:0] r_sq;
    logic [60:0] r_rad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq  <= r_sb[0].dot * r_sb[0].dot;
            r_rad <= (61'd1 << 60) - {r_sq[56:0], 4'b0000};
        end
    end

    // ---------------- square root cells: s30 ----------------
    qs_pkg::t_sqrt sq_c [NSQ+1];

    assign sq_c[0].rem  = r_rad;
    assign sq_c[0].root = '0;

    for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
        qs_sqrt_cell #(.K(NSQ - 1 - j)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (sq_c[j]),
            .o_d   (sq_c[j+1])
        );
    end

    // ---------------- vectoring cells: w = atan2(s, c) ----------------
    qs_pkg::t_cordic vc [N+1];

    assign vc[0].x = 34'({r_sb[SB_SQ].dot, 2'b00});
    assign vc[0].y = 34'(sq_c[NSQ].root);
    assign vc[0].z = '0;

    for (genvar i = 0; i < N; i++) begin : g_vec
        qs_cordic_cell #(.I(i), .VECTORING(1'b1)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (vc[i]),
            .o_d   (vc[i+1])
        );
    end

    // ---------------- angle split: (1-t)w and tw ----------------
    logic [30:0] w_clamp;
    logic [16:0] t_inv;
    logic [30:0] r_a1;
    logic [30:0] r_a2;
    logic [30:0] r_w;
    logic [47:0] m1;
    logic [47:0] m2;

    always_comb begin
        w_clamp = vc[N].z[32] ? 31'd0 : vc[N].z[30:0];
        t_inv   = 17'h10000 - r_sb[SB_VEC].t;
        m1      = t_inv * w_clamp;
        m2      = r_sb[SB_VEC].t * w_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1 <= m1[46:16];
            r_a2 <= m2[46:16];
            r_w  <= w_clamp;
        end
    end

    // ---------------- rotation cells: three sines ----------------
    qs_pkg::t_cordic rc1 [N+1];
    qs_pkg::t_cordic rc2 [N+1];
    qs_pkg::t_cordic rcs [N+1];

    assign rc1[0].x = 34'sd1073741824;
    assign rc1[0].y = '0;
    assign rc1[0].z = 33'(r_a1);
    assign rc2[0].x = 34'sd1073741824;
    assign rc2[0].y = '0;
    assign rc2[0].z = 33'(r_a2);
    assign rcs[0].x = 34'sd1073741824;
    assign rcs[0].y = '0;
    assign rcs[0].z = 33'(r_w);

    for (genvar i = 0; i < N; i++) begin : g_rot
        qs_cordic_cell #(.I(i), .VECTORING(1'b0)) u_c1 (
            .i_clk (i_clk), .i_en (en), .i_d (rc1[i]), .o_d (rc1[i+1])
        );
        qs_cordic_cell #(.I(i), .VECTORING(1'b0)) u_c2 (
            .i_clk (i_clk), .i_en (en), .i_d (rc2[i]), .o_d (rc2[i+1])
        );
        qs_cordic_cell #(.I(i), .VECTORING(1'b0)) u_cs (
            .i_clk (i_clk), .i_en (en), .i_d (rcs[i]), .o_d (rcs[i+1])
        );
    end

    // ---------------- divider setup: k = (Y << 16) / Ys ----------------
    logic [32:0]  y1c;
    logic [32:0]  y2c;
    logic         ys_ok;
    logic [32:0]  dvs;
    qs_pkg::t_div n_dv1;
    qs_pkg::t_div n_dv2;
    qs_pkg::t_div dv1 [NDV+1];
    qs_pkg::t_div dv2 [NDV+1];

    always_comb begin
        y1c   = rc1[N].y[33] ? 33'd0 : rc1[N].y[32:0];
        y2c   = rc2[N].y[33] ? 33'd0 : rc2[N].y[32:0];
        ys_ok = !rcs[N].y[33] && (rcs[N].y != '0);
        dvs   = ys_ok ? rcs[N].y[32:0] : 33'd1;
        // quotient of 2^21 or more is capped anyway
        n_dv1.cap = {5'd0, y1c} >= {dvs, 5'd0};
        n_dv2.cap = {5'd0, y2c} >= {dvs, 5'd0};
        n_dv1.rem = 55'({y1c, 16'd0});
        n_dv2.rem = 55'({y2c, 16'd0});
        n_dv1.q   = '0;
        n_dv2.q   = '0;
        n_dv1.d   = dvs;
        n_dv2.d   = dvs;
        n_dv1.ok  = ys_ok;
        n_dv2.ok  = ys_ok;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            dv1[0] <= n_dv1;
            dv2[0] <= n_dv2;
        end
    end

    for (genvar j = 0; j < NDV; j++) begin : g_div
        qs_div_cell #(.J(NDV - 1 - j)) u_d1 (
            .i_clk (i_clk), .i_en (en), .i_d (dv1[j]), .o_d (dv1[j+1])
        );
        qs_div_cell #(.J(NDV - 1 - j)) u_d2 (
            .i_clk (i_clk), .i_en (en), .i_d (dv2[j]), .o_d (dv2[j+1])
        );
    end

    // ---------------- weight select ----------------
    logic        use_lin;
    logic [20:0] k1;
    logic [20:0] k2;
    logic [20:0] r_k1;
    logic [20:0] r_k2;

    always_comb begin
        use_lin = !r_sb[SB_DIV].slerp || r_sb[SB_DIV].degen || !dv1[NDV].ok;
        k1 = (dv1[NDV].cap || dv1[NDV].q > 21'h100000) ? 21'h100000 : dv1[NDV].q;
        k2 = (dv2[NDV].cap || dv2[NDV].q > 21'h100000) ? 21'h100000 : dv2[NDV].q;
        if (use_lin) begin
            k1 = 21'(17'h10000 - r_sb[SB_DIV].t);
            k2 = 21'(r_sb[SB_DIV].t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k1 <= k1;
            r_k2 <= k2;
        end
    end

    // ---------------- weighted products ----------------
    logic signed [38:0] r_pa [4];
    logic signed [38:0] r_pb [4];
    logic signed [16:0] bn   [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            bn[i] = r_sb[SB_WGT].neg ? 17'(-$signed(r_sb[SB_WGT].b[i]))
                                     : 17'($signed(r_sb[SB_WGT].b[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_pa[i] <= $signed({1'b0, r_k1}) * $signed(r_sb[SB_WGT].a[i]);
                r_pb[i] <= $signed({1'b0, r_k2}) * bn[i];
            end
        end
    end

    // ---------------- round, saturate, special cases ----------------
    logic signed [39:0] acc  [4];
    logic signed [23:0] shv  [4];
    logic        [15:0] fin  [4];
    qs_pkg::t_out       n_out;
    qs_pkg::t_out       r_out;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            acc[i] = 40'(r_pa[i]) + 40'(r_pb[i]) + 40'sd32768;
            shv[i] = acc[i][39:16];
            if (shv[i] > 24'sd32767) begin
                fin[i] = 16'h7FFF;
            end else if (shv[i] < -24'sd32768) begin
                fin[i] = 16'h8000;
            end else begin
                fin[i] = shv[i][15:0];
            end
            if (r_sb[SB_PRD].at_eps) begin
                fin[i] = r_sb[SB_PRD].a[i];
            end else if (r_sb[SB_PRD].big) begin
                fin[i] = r_sb[SB_PRD].b[i];
            end
        end
        n_out.result_w = fin[0];
        n_out.result_x = fin[1];
        n_out.result_y = fin[2];
        n_out.result_z = fin[3];
    end

    always_ff @(posedge i_clk) begin
        if ((o_out.ready || !r_out_valid) && r_vl[SBL-1]) begin
            r_out <= n_out;
        end
    end

    assign o_out.data = r_out;

endmodule
`default_nettype wire

// File: hw/rtl/qs_sqrt_cell.sv
`default_nettype none
module qs_sqrt_cell #(
    parameter int K = 0
) (
    input  wire logic      i_clk,
    input  wire logic      i_en,
    input  qs_pkg::t_sqrt  i_d,
    output qs_pkg::t_sqrt  o_d
);
    logic [62:0]   trial;
    logic          ge;
    qs_pkg::t_sqrt n_d;
    qs_pkg::t_sqrt r_d;

    // (2r + 2^K) * 2^K against the remainder
    always_comb begin
        trial = ({32'd0, i_d.root} << (K + 1)) + (63'd1 << (2 * K));
        ge    = {2'b00, i_d.rem} >= trial;
        n_d   = i_d;
        if (ge) begin
            n_d.rem     = 61'({2'b00, i_d.rem} - trial);
            n_d.root[K] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

// File: hw/rtl/qs_cordic_cell.sv
`default_nettype none
module qs_cordic_cell #(
    parameter int I         = 0,
    parameter bit VECTORING = 1'b0
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  qs_pkg::t_cordic  i_d,
    output qs_pkg::t_cordic  o_d
);
    localparam logic signed [32:0] ANG = 33'(qs_pkg::ATAN_Q30[I]);

    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic               dir;
    qs_pkg::t_cordic    n_d;
    qs_pkg::t_cordic    r_d;

    // vectoring drives y to zero, rotation drives z to zero
    always_comb begin
        dx  = i_d.y >>> I;
        dy  = i_d.x >>> I;
        dir = VECTORING ? !i_d.y[33] : i_d.z[32];
        if (dir) begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + ANG;
        end else begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

// File: hw/rtl/qs_div_cell.sv
`default_nettype none
module qs_div_cell #(
    parameter int J = 0
) (
    input  wire logic     i_clk,
    input  wire logic     i_en,
    input  qs_pkg::t_div  i_d,
    output qs_pkg::t_div  o_d
);
    logic [54:0]  trial;
    qs_pkg::t_div n_d;
    qs_pkg::t_div r_d;

    always_comb begin
        trial = 55'(i_d.d) << J;
        n_d   = i_d;
        if (i_d.rem >= trial) begin
            n_d.rem  = i_d.rem - trial;
            n_d.q[J] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule
`default_nettype wire
